>>> sv/stls_pkg.sv
// Package with shared constants, types and helpers of the sorted table search block.
package stls_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 11;
    localparam int SLOT_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 10;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_PROBE,
        S_CHECK
    } t_state;

    typedef enum logic [1:0] {
        RD_MID_CUR,
        RD_MID_NEXT,
        RD_LO_CUR,
        RD_LO_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    issue;
        logic    step;
        logic    out_load;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic range_open;
        logic next_open;
    } t_status;

    function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
        return lo + ((hi - lo) >> 1);
    endfunction

endpackage

>>> sv/sorted_table_leftmost_search_core.sv
// Top level of the sorted table leftmost search block.
// The block holds a table of signed entries kept in ascending order by software. A write
// request stores one entry and gives no result, and a slot at or beyond the table depth is
// ignored. A search request runs a lower-bound binary search over the first entry_count
// entries and returns one result: a found flag and the lowest position holding the key, zero
// when not found. A search passes through an accept step, an issue step, the probes (up to
// ceil(log2(n+1)) probes for n entries, ten or eleven for 1024) and a check step; the table
// memory has a single read port and is read once per probe. The result is held in an output
// register, so a finished result may wait while the block accepts the next request.
// entry_count is to be written only while the block is idle; the block itself does not
// enforce this. Table entries that were never written read back undefined.
module sorted_table_leftmost_search_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [0:0]                          i_op,
    input  logic [stls_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [stls_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [stls_pkg::POS_W-1:0]          o_position,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stls_pkg::CFG_W-1:0]          i_cfg_data
);

    stls_pkg::t_cmd    s_cmd;
    stls_pkg::t_status s_status;
    logic              wr_en;

    assign o_cfg_ready = 1'b1;

    stls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op[0]),
        .o_in_stall (o_in_stall),
        .o_wr_en    (wr_en),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    stls_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_wr_en    (wr_en),
        .i_slot     (i_slot),
        .i_value    (i_value),
        .i_cmd      (s_cmd),
        .o_status   (s_status),
        .o_found    (o_found),
        .o_position (o_position)
    );

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while a result waits");

    // No probe runs while the block is open for requests.
    a_idle_no_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!s_cmd.step && !s_cmd.issue))
        else $error("probe while idle");

    // Accepting a search closes the input until the search ends.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |=> o_in_stall)
        else $error("input open right after search accept");

    // A miss always reports position zero.
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_position == '0))
        else $error("miss with nonzero position");

endmodule

>>> sv/stls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/stls_ctrl.sv
// Controller state machine that sequences accepts, probes and result delivery.
module stls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op,
    output logic             o_in_stall,
    output logic             o_wr_en,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  stls_pkg::t_status i_status,
    output stls_pkg::t_cmd   o_cmd
);

    stls_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stls_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        accept       = i_in_valid && (r_state == stls_pkg::S_IDLE);
        out_free     = !r_out_valid || !i_out_stall;
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_in_stall   = (r_state != stls_pkg::S_IDLE);
        o_wr_en      = accept && (i_op == stls_pkg::OP_WRITE);
        o_cmd        = '0;
        o_cmd.rd_sel = stls_pkg::RD_MID_CUR;
        unique case (r_state)
            stls_pkg::S_IDLE: begin
                if (accept && (i_op == stls_pkg::OP_SEARCH)) begin
                    o_cmd.load = 1'b1;
                    n_state    = stls_pkg::S_ISSUE;
                end
            end
            stls_pkg::S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_status.range_open) begin
                    o_cmd.rd_sel = stls_pkg::RD_MID_CUR;
                    n_state      = stls_pkg::S_PROBE;
                end else begin
                    o_cmd.rd_sel = stls_pkg::RD_LO_CUR;
                    n_state      = stls_pkg::S_CHECK;
                end
            end
            stls_pkg::S_PROBE: begin
                o_cmd.step = 1'b1;
                if (i_status.next_open) begin
                    o_cmd.rd_sel = stls_pkg::RD_MID_NEXT;
                end else begin
                    o_cmd.rd_sel = stls_pkg::RD_LO_NEXT;
                    n_state      = stls_pkg::S_CHECK;
                end
            end
            stls_pkg::S_CHECK: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = stls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stls_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/stls_dp.sv
// Datapath with the entry table, search bounds, count register and result registers.
module stls_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [stls_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_wr_en,
    input  logic [stls_pkg::SLOT_W-1:0]      i_slot,
    input  logic signed [stls_pkg::VALUE_W-1:0] i_value,
    input  stls_pkg::t_cmd                   i_cmd,
    output stls_pkg::t_status                o_status,
    output logic                             o_found,
    output logic [stls_pkg::POS_W-1:0]       o_position
);

    localparam int CW = stls_pkg::CNT_W;
    localparam int AW = stls_pkg::ADDR_W;
    localparam int DW = stls_pkg::DATA_WIDTH;

    logic [stls_pkg::CFG_W-1:0]   r_count;
    logic [CW-1:0]                r_lo, r_hi, r_n;
    logic [CW-1:0]                r_mid;
    logic [DW-1:0]                r_key;
    logic                         r_found;
    logic [stls_pkg::POS_W-1:0]   r_position;

    logic [63:0]                  value_ext;
    logic [DW-1:0]                entry_in;
    logic [CW-1:0]                n_lim;
    logic [CW-1:0]                mid_cur, n_lo, n_hi, n_mid;
    logic [DW-1:0]                rdata;
    logic                         less;
    logic                         hit;
    logic                         ram_we;
    logic                         ram_re;
    logic [CW-1:0]                rd_full;

    always_comb begin
        value_ext = {{32{i_value[stls_pkg::VALUE_W-1]}}, i_value};
        entry_in  = value_ext[DW-1:0];
        if (32'(r_count) > 32'(stls_pkg::DEPTH)) begin
            n_lim = CW'(stls_pkg::DEPTH);
        end else begin
            n_lim = CW'(r_count);
        end
        mid_cur = stls_pkg::mid_of(r_lo, r_hi);
        less    = $signed(rdata) < $signed(r_key);
        n_lo    = less ? (r_mid + CW'(1)) : r_lo;
        n_hi    = less ? r_hi : r_mid;
        n_mid   = stls_pkg::mid_of(n_lo, n_hi);
        hit     = (r_lo < r_n) && (rdata == r_key);
        ram_we  = i_wr_en && (32'(i_slot) < 32'(stls_pkg::DEPTH));
        ram_re  = i_cmd.issue || i_cmd.step;
        unique case (i_cmd.rd_sel)
            stls_pkg::RD_MID_CUR:  rd_full = mid_cur;
            stls_pkg::RD_MID_NEXT: rd_full = n_mid;
            stls_pkg::RD_LO_CUR:   rd_full = r_lo;
            stls_pkg::RD_LO_NEXT:  rd_full = n_lo;
            default:               rd_full = r_lo;
        endcase
        o_status.range_open = r_lo < r_hi;
        o_status.next_open  = n_lo < n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= entry_in;
            r_lo  <= '0;
            r_hi  <= n_lim;
            r_n   <= n_lim;
        end
        if (i_cmd.issue) begin
            r_mid <= mid_cur;
        end
        if (i_cmd.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        if (i_cmd.out_load) begin
            r_found    <= hit;
            r_position <= hit ? stls_pkg::POS_W'(r_lo) : '0;
        end
    end

    stls_ram #(
        .WIDTH(DW),
        .DEPTH(stls_pkg::DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(i_slot)),
        .i_wdata(entry_in),
        .i_re   (ram_re),
        .i_raddr(rd_full[AW-1:0]),
        .o_rdata(rdata)
    );

    assign o_found    = r_found;
    assign o_position = r_position;

endmodule
